### rtl/sparse_row_dot_accumulate_unit_macros.svh
// Assertion macros used by the checker of the sparse row dot accumulate unit.
`ifndef SPARSE_ROW_DOT_ACCUMULATE_UNIT_MACROS_SVH
`define SPARSE_ROW_DOT_ACCUMULATE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SRDA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SRDA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/srda_pkg.sv
// Package: widths, codes, queue sizing and the queued request type.
`timescale 1ns / 1ps
package srda_pkg;

   localparam int IDX_W = 10;
   localparam int VAL_W = 32;
   localparam int SUM_W = 48;
   localparam int PROD_W = 2 * VAL_W;

   localparam int VEC_DEPTH_DEF = 1024;
   localparam int FRAC_BITS_DEF = 16;

   // Queue between front and back; four requests ride out short result stalls.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_ELEMENT = 1'b1;

   typedef struct packed {
      logic                    is_elem;
      logic                    in_range;
      logic [IDX_W-1:0]        entry_index;
      logic signed [VAL_W-1:0] entry_value;
      logic                    row_end;
      logic [IDX_W-1:0]        row_index;
      logic signed [VAL_W-1:0] dest_in;
   } item_type;

endpackage

### rtl/srda_if.sv
// Request and result channel interfaces with valid/ready handshake.
`timescale 1ns / 1ps
interface srda_req_if import srda_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    kind;
   logic [IDX_W-1:0]        entry_index;
   logic signed [VAL_W-1:0] entry_value;
   logic                    row_end;
   logic [IDX_W-1:0]        row_index;
   logic signed [VAL_W-1:0] dest_in;

   modport source (output valid, kind, entry_index, entry_value, row_end, row_index, dest_in,
                   input ready);
   modport sink (input valid, kind, entry_index, entry_value, row_end, row_index, dest_in,
                 output ready);
endinterface

interface srda_rsp_if import srda_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [IDX_W-1:0]        row_out;
   logic signed [VAL_W-1:0] row_value;
   logic                    saturated;

   modport source (output valid, row_out, row_value, saturated, input ready);
   modport sink (input valid, row_out, row_value, saturated, output ready);
endinterface

### rtl/srda_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module srda_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      // Hold read data while no read is issued.
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/srda_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module srda_front import srda_pkg::*; #(
   parameter int VEC_DEPTH = VEC_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   srda_req_if.sink req,
   output logic     q_valid,
   output item_type q_item,
   input  logic     q_pop
);

   item_type          mem_ff [QUEUE_DEPTH];
   item_type          mem_in [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   item_type          new_item;
   logic              push;

   assign req.ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push = req.valid && req.ready;
   assign q_valid = (count_ff != '0);
   assign q_item = mem_ff[rd_ptr_ff];

   // Classify: kind decode and range check of the index against the store depth.
   always_comb begin
      new_item.is_elem = (req.kind == KIND_ELEMENT);
      new_item.in_range = (32'(req.entry_index) < 32'(VEC_DEPTH));
      new_item.entry_index = req.entry_index;
      new_item.entry_value = req.entry_value;
      new_item.row_end = req.row_end;
      new_item.row_index = req.row_index;
      new_item.dest_in = req.dest_in;
   end

   always_comb begin
      mem_in = mem_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         mem_in[wr_ptr_ff] = new_item;
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, q_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

### rtl/srda_back.sv
// Back end: source store, multiply, round, accumulate and row result output.
`timescale 1ns / 1ps
module srda_back import srda_pkg::*; #(
   parameter int VEC_DEPTH = VEC_DEPTH_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  item_type   q_item,
   output logic       q_pop,
   srda_rsp_if.source rsp
);

   localparam int ADDR_W = $clog2(VEC_DEPTH);
   localparam logic signed [PROD_W-1:0] ROUND_C = (PROD_W'(1) << FRAC_BITS) >> 1;
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   typedef struct packed {
      logic                    row_end;
      logic [IDX_W-1:0]        row_index;
      logic signed [VAL_W-1:0] dest_in;
   } tail_type;

   logic                     en;
   logic                     ram_we, ram_re;
   logic [ADDR_W-1:0]        ram_addr;
   logic [VAL_W-1:0]         ram_rdata;
   tail_type                 q_tail;

   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_range_ff, s1_range_in;
   logic signed [VAL_W-1:0]  s1_value_ff, s1_value_in;
   tail_type                 s1_tail_ff, s1_tail_in;
   logic signed [VAL_W-1:0]  src_sel;

   logic                     s2_valid_ff, s2_valid_in;
   logic signed [PROD_W-1:0] s2_prod_ff, s2_prod_in;
   tail_type                 s2_tail_ff, s2_tail_in;
   logic signed [PROD_W-1:0] rounded;

   logic                     s3_valid_ff, s3_valid_in;
   logic signed [SUM_W-1:0]  s3_prod_ff, s3_prod_in;
   tail_type                 s3_tail_ff, s3_tail_in;
   logic signed [SUM_W:0]    acc_wide;
   logic signed [SUM_W-1:0]  acc;

   logic signed [SUM_W-1:0]  row_sum_ff, row_sum_in;

   logic                     s4_valid_ff, s4_valid_in;
   logic signed [SUM_W-1:0]  s4_sum_ff, s4_sum_in;
   logic [IDX_W-1:0]         s4_row_ff, s4_row_in;
   logic signed [VAL_W-1:0]  s4_dest_ff, s4_dest_in;
   logic signed [SUM_W:0]    total_wide;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]         row_out_ff, row_out_in;
   logic signed [VAL_W-1:0]  row_value_ff, row_value_in;
   logic                     sat_ff, sat_in;

   // Whole back pipeline advances while the output register can take a result.
   assign en = !rsp_valid_ff || rsp.ready;
   assign q_pop = q_valid && en;

   // Loads and reads go through the store in queue order.
   assign ram_we = q_pop && !q_item.is_elem && q_item.in_range;
   assign ram_re = q_pop && q_item.is_elem && q_item.in_range;
   assign ram_addr = ADDR_W'(q_item.entry_index);

   srda_ram #(
      .WIDTH(VAL_W),
      .DEPTH(VEC_DEPTH)
   ) u_store (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_addr),
      .wdata(q_item.entry_value),
      .re(ram_re),
      .raddr(ram_addr),
      .rdata(ram_rdata)
   );

   assign q_tail = '{row_end: q_item.row_end, row_index: q_item.row_index,
                     dest_in: q_item.dest_in};

   // Stage 1: store read in flight.
   assign s1_valid_in = en ? (q_pop && q_item.is_elem) : s1_valid_ff;
   assign s1_range_in = en ? q_item.in_range : s1_range_ff;
   assign s1_value_in = en ? q_item.entry_value : s1_value_ff;
   assign s1_tail_in = en ? q_tail : s1_tail_ff;

   // Stage 2: full product; a column beyond the store reads as zero.
   assign src_sel = s1_range_ff ? signed'(ram_rdata) : '0;
   assign s2_valid_in = en ? s1_valid_ff : s2_valid_ff;
   assign s2_prod_in = en ? s1_value_ff * src_sel : s2_prod_ff;
   assign s2_tail_in = en ? s1_tail_ff : s2_tail_ff;

   // Stage 3: round half up back to the fraction width, clip to the sum width.
   assign rounded = (s2_prod_ff + ROUND_C) >>> FRAC_BITS;
   always_comb begin
      s3_prod_in = s3_prod_ff;
      if (en) begin
         if ((&rounded[PROD_W-1:SUM_W-1]) || !(|rounded[PROD_W-1:SUM_W-1])) begin
            s3_prod_in = rounded[SUM_W-1:0];
         end else begin
            s3_prod_in = rounded[PROD_W-1] ? SUM_MIN : SUM_MAX;
         end
      end
   end
   assign s3_valid_in = en ? s2_valid_ff : s3_valid_ff;
   assign s3_tail_in = en ? s2_tail_ff : s3_tail_ff;

   // Stage 4: accumulate, loop through the row sum register; clear at row end.
   assign acc_wide = {row_sum_ff[SUM_W-1], row_sum_ff} + {s3_prod_ff[SUM_W-1], s3_prod_ff};
   always_comb begin
      if (acc_wide[SUM_W] != acc_wide[SUM_W-1]) begin
         acc = acc_wide[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         acc = acc_wide[SUM_W-1:0];
      end
      row_sum_in = row_sum_ff;
      if (en && s3_valid_ff) begin
         row_sum_in = s3_tail_ff.row_end ? '0 : acc;
      end
   end
   assign s4_valid_in = en ? (s3_valid_ff && s3_tail_ff.row_end) : s4_valid_ff;
   assign s4_sum_in = en ? acc : s4_sum_ff;
   assign s4_row_in = en ? s3_tail_ff.row_index : s4_row_ff;
   assign s4_dest_in = en ? s3_tail_ff.dest_in : s4_dest_ff;

   // Output: add the destination, clip to 32 bits and flag the clip.
   assign total_wide = {s4_sum_ff[SUM_W-1], s4_sum_ff}
                       + {{(SUM_W+1-VAL_W){s4_dest_ff[VAL_W-1]}}, s4_dest_ff};
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      row_out_in = row_out_ff;
      row_value_in = row_value_ff;
      sat_in = sat_ff;
      if (en) begin
         rsp_valid_in = s4_valid_ff;
         row_out_in = s4_row_ff;
         if ((&total_wide[SUM_W:VAL_W-1]) || !(|total_wide[SUM_W:VAL_W-1])) begin
            row_value_in = total_wide[VAL_W-1:0];
            sat_in = 1'b0;
         end else begin
            row_value_in = total_wide[SUM_W] ? VAL_MIN : VAL_MAX;
            sat_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_range_ff <= s1_range_in;
      s1_value_ff <= s1_value_in;
      s1_tail_ff <= s1_tail_in;
      s2_prod_ff <= s2_prod_in;
      s2_tail_ff <= s2_tail_in;
      s3_prod_ff <= s3_prod_in;
      s3_tail_ff <= s3_tail_in;
      s4_sum_ff <= s4_sum_in;
      s4_row_ff <= s4_row_in;
      s4_dest_ff <= s4_dest_in;
      row_out_ff <= row_out_in;
      row_value_ff <= row_value_in;
      sat_ff <= sat_in;
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         row_sum_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         row_sum_ff <= row_sum_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.row_out = row_out_ff;
   assign rsp.row_value = row_value_ff;
   assign rsp.saturated = sat_ff;

endmodule

### rtl/sparse_row_dot_accumulate_unit.sv
// Top level of the sparse row dot accumulate unit.
//
// Streams one compressed-row nonzero, or one source vector load, per clock: a new
// request is taken every cycle while the four-entry request queue has room. Each
// element is one multiply-accumulate; the rate is set by the loop on the 48-bit
// row sum register and the one write-or-read access per cycle to the source
// store RAM. A stalled result only halts the back pipeline; the front keeps
// taking requests until the queue fills. The source store has no reset and no
// clearing pass: read only entries that were loaded. Loads to an index beyond
// the store are dropped, and elements with such a column use a zero source value.
`timescale 1ns / 1ps
module sparse_row_dot_accumulate_unit import srda_pkg::*; #(
   parameter int VEC_DEPTH = VEC_DEPTH_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   srda_req_if.sink   req,
   srda_rsp_if.source rsp
);

   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   srda_front #(
      .VEC_DEPTH(VEC_DEPTH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req(req),
      .q_valid(q_valid),
      .q_item(q_item),
      .q_pop(q_pop)
   );

   srda_back #(
      .VEC_DEPTH(VEC_DEPTH),
      .FRAC_BITS(FRAC_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_item(q_item),
      .q_pop(q_pop),
      .rsp(rsp)
   );

endmodule

### rtl/srda_checker.sv
// Port-level checker for the sparse row dot accumulate unit, with its bind.
`timescale 1ns / 1ps
`include "sparse_row_dot_accumulate_unit_macros.svh"
module srda_checker import srda_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [IDX_W-1:0]        rsp_row_out,
   input logic signed [VAL_W-1:0] rsp_row_value,
   input logic                    rsp_saturated
);

   // A stalled result holds.
   `SRDA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_row_out) && $stable(rsp_row_value) && $stable(rsp_saturated), "stalled result changed")

   // No result right out of reset.
   `SRDA_ASSERT_IMP(a_reset_quiet, clock, reset, $past(reset), !rsp_valid, "result right after reset")

   // A clipped result sits at one of the range limits.
   `SRDA_ASSERT_IMP(a_sat_limit, clock, reset, rsp_valid && rsp_saturated, rsp_row_value == 32'sh7FFF_FFFF || rsp_row_value == 32'sh8000_0000, "clip flag without limit value")

   // The request side only backs up behind a stalled result.
   `SRDA_ASSERT_IMP(a_ready_drop, clock, reset, $fell(req_ready), $past(rsp_valid && !rsp_ready), "request ready dropped without result stall")

endmodule

bind sparse_row_dot_accumulate_unit srda_checker u_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req.valid),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_row_out(rsp.row_out),
   .rsp_row_value(rsp.row_value),
   .rsp_saturated(rsp.saturated)
);

### tb/testbench.sv
// Self-checking testbench for the sparse row dot accumulate unit.
`timescale 1ns / 1ps
module testbench import srda_pkg::*; ();

   localparam int  DIR_ROWS = 18;
   localparam longint SUM_MAX = (longint'(1) <<< (SUM_W - 1)) - 1;
   localparam longint SUM_MIN = -SUM_MAX - 1;
   localparam longint OUT_MAX = (longint'(1) <<< (VAL_W - 1)) - 1;
   localparam longint OUT_MIN = -OUT_MAX - 1;
   localparam logic signed [VAL_W-1:0] Q_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] Q_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   typedef struct packed {
      logic                    kind;
      logic [IDX_W-1:0]        idx;
      logic signed [VAL_W-1:0] val;
      logic                    row_end;
      logic [IDX_W-1:0]        row;
      logic signed [VAL_W-1:0] dest;
   } request_type;

   typedef struct packed {
      logic [IDX_W-1:0]        row;
      logic signed [VAL_W-1:0] value;
      logic                    sat;
   } row_result_type;

   // Expected value is typed in only on rows that carry a flag; the rest use the predictor.
   typedef struct packed {
      logic                    typed;
      request_type             req;
      logic signed [VAL_W-1:0] exp_value;
      logic                    exp_sat;
   } dir_row_type;

   localparam dir_row_type DIRECTED_ROWS [DIR_ROWS] = '{
      // source loads at both ends of the store and the value extremes
      '{1'b0, '{KIND_LOAD, 10'd0, 32'sh0001_0000, 1'b0, 10'd0, 32'sh0}, 32'sh0, 1'b0},
      '{1'b0, '{KIND_LOAD, 10'd1023, Q_MAX, 1'b0, 10'd0, 32'sh0}, 32'sh0, 1'b0},
      '{1'b0, '{KIND_LOAD, 10'd1, Q_MIN, 1'b0, 10'd0, 32'sh0}, 32'sh0, 1'b0},
      '{1'b0, '{KIND_LOAD, 10'd2, -32'sd1, 1'b0, 10'd0, 32'sh0}, 32'sh0, 1'b0},
      // single element rows: plain, clip high, clip low
      '{1'b1, '{KIND_ELEMENT, 10'd0, 32'sh0002_0000, 1'b1, 10'd0, 32'sh0},
        32'sh0002_0000, 1'b0},
      '{1'b1, '{KIND_ELEMENT, 10'd0, 32'sh0001_0000, 1'b1, 10'd1023, Q_MAX}, Q_MAX, 1'b1},
      '{1'b1, '{KIND_ELEMENT, 10'd0, -32'sh0001_0000, 1'b1, 10'd5, Q_MIN}, Q_MIN, 1'b1},
      // largest products drive the 48-bit sum into its limit
      '{1'b0, '{KIND_ELEMENT, 10'd1, Q_MIN, 1'b0, 10'd8, 32'sh0}, 32'sh0, 1'b0},
      '{1'b0, '{KIND_ELEMENT, 10'd1, Q_MIN, 1'b0, 10'd8, 32'sh0}, 32'sh0, 1'b0},
      '{1'b1, '{KIND_ELEMENT, 10'd1, Q_MIN, 1'b1, 10'd8, Q_MIN}, Q_MAX, 1'b1},
      // rounding: exact half goes up to zero, just past half goes down to -1
      '{1'b0, '{KIND_ELEMENT, 10'd2, 32'sh0000_8000, 1'b0, 10'd3, 32'sh0}, 32'sh0, 1'b0},
      '{1'b1, '{KIND_ELEMENT, 10'd2, 32'sh0000_8001, 1'b1, 10'd3, 32'sh0}, -32'sd1, 1'b0},
      '{1'b1, '{KIND_ELEMENT, 10'd1023, Q_MAX, 1'b1, 10'd1023, 32'sh0}, Q_MAX, 1'b1},
      // overwrite an entry, then use it
      '{1'b0, '{KIND_LOAD, 10'd0, 32'sh0, 1'b0, 10'd0, 32'sh0}, 32'sh0, 1'b0},
      '{1'b1, '{KIND_ELEMENT, 10'd0, Q_MAX, 1'b1, 10'd7, 32'sh1234_5678},
        32'sh1234_5678, 1'b0},
      // a load inside a row keeps the partial sum; its row fields are ignored
      '{1'b0, '{KIND_ELEMENT, 10'd1023, 32'sd1, 1'b0, 10'd2, 32'sh0}, 32'sh0, 1'b0},
      '{1'b0, '{KIND_LOAD, 10'd3, 32'sh0003_0000, 1'b1, 10'd1023, Q_MAX}, 32'sh0, 1'b0},
      '{1'b1, '{KIND_ELEMENT, 10'd3, 32'sh0001_0000, 1'b1, 10'd2, 32'sh0},
        32'sh0003_8000, 1'b0}
   };

   logic clock;
   logic reset;

   srda_req_if req_ch ();
   srda_rsp_if rsp_ch ();

   sparse_row_dot_accumulate_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // predictor state
   logic signed [VAL_W-1:0] source_copy [VEC_DEPTH_DEF];
   bit                      source_loaded [VEC_DEPTH_DEF];
   logic [IDX_W-1:0]        loaded_cols [$];
   longint                  row_acc;

   row_result_type pending_rows [$];
   int             mismatches = 0;
   int             send_gap_pct = 0;
   int             rsp_stall_pct = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("sparse_row_dot_accumulate_unit regression: fail");
      $finish;
   end

   // result receiver: stall at random at every falling edge
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   function automatic longint clip_sum(input longint v);
      if (v > SUM_MAX) return SUM_MAX;
      if (v < SUM_MIN) return SUM_MIN;
      return v;
   endfunction

   function automatic void accumulate_request(input request_type r, output bit produced,
                                              output row_result_type res);
      longint prod;
      longint total;
      logic signed [VAL_W-1:0] src;
      produced = 1'b0;
      res = '0;
      if (r.kind == KIND_LOAD) begin
         if (int'(r.idx) < VEC_DEPTH_DEF) begin
            source_copy[r.idx] = r.val;
            if (!source_loaded[r.idx]) loaded_cols.push_back(r.idx);
            source_loaded[r.idx] = 1'b1;
         end
         return;
      end
      src = (int'(r.idx) < VEC_DEPTH_DEF) ? source_copy[r.idx] : '0;
      prod = longint'(r.val) * longint'(src);
      if (FRAC_BITS_DEF > 0)
         prod = (prod + (longint'(1) <<< (FRAC_BITS_DEF - 1))) >>> FRAC_BITS_DEF;
      row_acc = clip_sum(row_acc + clip_sum(prod));
      if (!r.row_end) return;
      total = row_acc + longint'(r.dest);
      res.sat = 1'b0;
      if (total > OUT_MAX) begin
         total = OUT_MAX;
         res.sat = 1'b1;
      end
      if (total < OUT_MIN) begin
         total = OUT_MIN;
         res.sat = 1'b1;
      end
      res.row = r.row;
      res.value = total[VAL_W-1:0];
      row_acc = 0;
      produced = 1'b1;
   endfunction

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic send_request(input request_type r, input bit typed,
                               input logic signed [VAL_W-1:0] typed_value,
                               input logic typed_sat);
      row_result_type predicted;
      bit             produced;
      while ($urandom_range(99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.kind        <= r.kind;
      req_ch.entry_index <= r.idx;
      req_ch.entry_value <= r.val;
      req_ch.row_end     <= r.row_end;
      req_ch.row_index   <= r.row;
      req_ch.dest_in     <= r.dest;
      do @(posedge clock); while (!req_ch.ready);
      accumulate_request(r, produced, predicted);
      if (typed) begin
         predicted.row = r.row;
         predicted.value = typed_value;
         predicted.sat = typed_sat;
      end
      if (produced || typed) pending_rows.push_back(predicted);
      @(negedge clock);
   endtask

   function automatic logic signed [VAL_W-1:0] random_q16();
      case ($urandom_range(9))
         0: return Q_MAX;
         1: return Q_MIN;
         2, 3, 4: return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
         default: return $urandom();
      endcase
   endfunction

   task automatic emit_load(inout int issued);
      request_type r;
      r.kind = KIND_LOAD;
      r.idx = IDX_W'($urandom());
      r.val = random_q16();
      r.row_end = 1'($urandom());
      r.row = IDX_W'($urandom());
      r.dest = VAL_W'($urandom());
      send_request(r, 1'b0, '0, 1'b0);
      issued++;
   endtask

   // Broken rows change row_index per element and slip loads in between elements.
   task automatic emit_row(input int len, input bit broken, inout int issued);
      request_type      r;
      logic [IDX_W-1:0] row;
      row = IDX_W'($urandom());
      for (int k = 0; k < len; k++) begin
         if (broken && $urandom_range(3) == 0) emit_load(issued);
         r.kind = KIND_ELEMENT;
         r.idx = loaded_cols[$urandom_range(loaded_cols.size() - 1)];
         r.val = random_q16();
         r.row_end = (k == len - 1);
         r.row = broken ? IDX_W'($urandom()) : row;
         r.dest = random_q16();
         send_request(r, 1'b0, '0, 1'b0);
         issued++;
      end
   endtask

   task automatic run_random(input int count);
      int issued;
      int pick;
      issued = 0;
      while (issued < count) begin
         pick = $urandom_range(99);
         if (loaded_cols.size() < 16 || pick < 15) emit_load(issued);
         else if (pick < 25) emit_row($urandom_range(1, 12), 1'b1, issued);
         else if (pick < 28) emit_row($urandom_range(16, 40), 1'b0, issued);
         else emit_row($urandom_range(1, 6), 1'b0, issued);
      end
   endtask

   // Hold the request channel until every expected row result is back.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      row_result_type exp_row;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_rows.size() == 0) begin
            $error("unexpected row result: row_out %0d row_value %0h",
                   rsp_ch.row_out, rsp_ch.row_value);
            mismatches++;
         end else begin
            exp_row = pending_rows.pop_front();
            if (rsp_ch.row_out !== exp_row.row) begin
               $error("row_out: expected %0d, actual %0d", exp_row.row, rsp_ch.row_out);
               mismatches++;
            end
            if (rsp_ch.row_value !== exp_row.value) begin
               $error("row_value: expected %0h, actual %0h", exp_row.value,
                      rsp_ch.row_value);
               mismatches++;
            end
            if (rsp_ch.saturated !== exp_row.sat) begin
               $error("saturated: expected %0b, actual %0b", exp_row.sat,
                      rsp_ch.saturated);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int wait_cycles;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_LOAD;
      req_ch.entry_index = '0;
      req_ch.entry_value = '0;
      req_ch.row_end = 1'b0;
      req_ch.row_index = '0;
      req_ch.dest_in = '0;
      row_acc = 0;
      foreach (source_loaded[i]) source_loaded[i] = 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_gap_pct = 33;
      rsp_stall_pct = 76;
      for (int i = 0; i < DIR_ROWS; i++)
         send_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed,
                      DIRECTED_ROWS[i].exp_value, DIRECTED_ROWS[i].exp_sat);
      run_random(620);
      drain_results();

      send_gap_pct = 76;
      rsp_stall_pct = 33;
      run_random(620);
      drain_results();

      send_gap_pct = 0;
      rsp_stall_pct = 0;
      run_random(610);
      req_ch.valid <= 1'b0;

      while (pending_rows.size() != 0) @(posedge clock);
      // let the back pipeline settle so stray results get flagged
      wait_cycles = 0;
      while (wait_cycles < 16) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (mismatches == 0) begin
         $display("sparse_row_dot_accumulate_unit regression: pass");
      end else begin
         $display("sparse_row_dot_accumulate_unit regression: fail");
      end
      $finish;
   end

endmodule
